>>> src/rgm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RGB gradient magnitude block.
// No dependencies; every other file but the line store imports this package.
package rgm_pkg;

	localparam int PX_W = 8;
	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] WIDTH_RST = 11'd64;
	localparam int MAX_WIDTH_DEF = 1024;

	// sum of two 8-bit squares stays below 2^17
	localparam int SQ_W = 17;
	localparam logic [SQ_W-1:0] SQRT_ONE = 17'h10000;

	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_LATER = 2'd2;

	typedef struct packed {
		logic [PX_W-1:0] chan0;
		logic [PX_W-1:0] chan1;
		logic [PX_W-1:0] chan2;
		logic flush;
	} pix_t;

	typedef struct packed {
		logic [PX_W-1:0] mag0;
		logic [PX_W-1:0] mag1;
		logic [PX_W-1:0] mag2;
		logic row_end;
		logic frame_end;
	} res_t;

	typedef struct packed {
		logic row_end;
		logic frame_end;
	} tag_t;

endpackage

>>> src/rgm_line_store.sv
`timescale 1ns / 1ps
// Two-line pixel store: one write port, two registered read ports.
// Uses nothing from the package; widths come from the parent.
module rgm_line_store #(
	parameter int AW = 11,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en_a,
	input  logic [AW-1:0] rd_addr_a,
	output logic [DW-1:0] rd_data_a,
	input  logic          rd_en_b,
	input  logic [AW-1:0] rd_addr_b,
	output logic [DW-1:0] rd_data_b
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en_a) begin
			rd_data_a <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

>>> src/rgm_lane.sv
`timescale 1ns / 1ps
// One color lane: squared central differences, then a bit-serial square root.
// Depends on rgm_pkg for pixel and accumulator widths.
module rgm_lane import rgm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [PX_W-1:0] cur_px,
	input  logic [PX_W-1:0] above_px,
	input  logic [PX_W-1:0] left_px,
	input  logic [PX_W-1:0] right_px,
	output logic            done,
	output logic [PX_W-1:0] mag
);

	logic [PX_W-1:0] dx, dy;
	logic [2*PX_W-1:0] dx_sq, dy_sq;
	logic [SQ_W-1:0] sum;
	logic [SQ_W:0] trial;
	logic ge;

	logic run_q;
	logic [SQ_W-1:0] one_q;
	logic [SQ_W-1:0] x_q;
	logic [SQ_W-1:0] root_q;

	assign dx = (right_px >= left_px) ? right_px - left_px : left_px - right_px;
	assign dy = (cur_px >= above_px) ? cur_px - above_px : above_px - cur_px;
	assign dx_sq = (2*PX_W)'(dx) * (2*PX_W)'(dx);
	assign dy_sq = (2*PX_W)'(dy) * (2*PX_W)'(dy);
	assign sum = SQ_W'(dx_sq) + SQ_W'(dy_sq);

	assign trial = {1'b0, root_q} + {1'b0, one_q};
	assign ge = {1'b0, x_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			one_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			one_q <= SQRT_ONE;
		end else if (run_q && one_q != '0) begin
			one_q <= one_q >> 2;
		end
	end

	// one result bit per cycle, highest first
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= sum;
			root_q <= '0;
		end else if (run_q && one_q != '0) begin
			if (ge) begin
				x_q <= x_q - trial[SQ_W-1:0];
				root_q <= (root_q >> 1) + one_q;
			end else begin
				root_q <= root_q >> 1;
			end
		end
	end

	assign done = run_q && one_q == '0;
	assign mag = (|root_q[SQ_W-1:PX_W]) ? {PX_W{1'b1}} : root_q[PX_W-1:0];

endmodule

>>> src/rgm_merge.sv
`timescale 1ns / 1ps
// Merges the three lane magnitudes and the row/frame tags into the output beat.
// Depends on rgm_pkg for res_t and tag_t.
module rgm_merge import rgm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [2:0][PX_W-1:0] mags,
	input  tag_t                 tag,
	output logic                 rdy,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res
);

	logic valid_q;
	res_t res_q;

	assign rdy = !valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.mag0 <= mags[0];
			res_q.mag1 <= mags[1];
			res_q.mag2 <= mags[2];
			res_q.row_end <= tag.row_end;
			res_q.frame_end <= tag.frame_end;
		end
	end

	assign res_valid = valid_q;
	assign res = res_q;

endmodule

>>> src/rgb_gradient_magnitude.sv
`timescale 1ns / 1ps
// Per-channel central-difference gradient magnitude over a raster pixel stream.
// A pixel is accepted only in the idle state; a new one waits until the last has been stored
// and, past the first row, its result has been loaded into the merge register, which the
// 9-step bit-serial square root in each lane and output back-pressure can hold up.
// Reset (arst_n, async): frame restarts at row 0, column 0, width 64; no clearing pass.
module rgb_gradient_magnitude import rgm_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  pix_t             pix,
	output logic             res_valid,
	input  logic             res_stall,
	output res_t             res
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int AW = CW + 1;
	localparam int DW = 3 * PX_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_WR = 3'd2;
	localparam logic [2:0] S_SQRT = 3'd3;

	logic [2:0] state_q;
	logic [CFG_W-1:0] width_q;
	logic [CW-1:0] col_q;
	logic [1:0] phase_q;
	logic lsel_q;

	logic [DW-1:0] cur_q;
	logic [DW-1:0] left_q;
	logic [AW-1:0] wr_addr_q;
	logic left_ok_q, right_ok_q, above_ok_q, has_res_q;
	tag_t tag_q;

	logic [WW-1:0] w_eff, col_p1;
	logic last, idle_flush, accept;
	logic rd_en_a;
	logic [AW-1:0] rd_addr_a, rd_addr_b;
	logic [DW-1:0] rd_data_a, rd_data_b;
	logic [DW-1:0] above_px, right_px;
	logic lane_start;
	logic [2:0] lane_done;
	logic [2:0][PX_W-1:0] mags;
	logic merge_rdy, merge_load;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
	end

	assign col_p1 = WW'(col_q) + WW'(1);
	assign last = col_p1 >= w_eff;
	assign idle_flush = pix.flush && phase_q == PH_FIRST && col_q == '0;
	assign pix_stall = state_q != S_IDLE;
	assign accept = pix_valid && !pix_stall;

	// side neighbors from the previous line on accept, the line above it in the cycle after
	assign rd_en_a = accept || state_q == S_RD;
	assign rd_addr_a = (state_q == S_RD) ? wr_addr_q : {lsel_q, col_q - CW'(1)};
	assign rd_addr_b = {lsel_q, col_q + CW'(1)};

	rgm_line_store #(
		.AW(AW),
		.DW(DW)
	) u_store (
		.clk      (clk),
		.wr_en    (state_q == S_WR),
		.wr_addr  (wr_addr_q),
		.wr_data  (cur_q),
		.rd_en_a  (rd_en_a),
		.rd_addr_a(rd_addr_a),
		.rd_data_a(rd_data_a),
		.rd_en_b  (accept),
		.rd_addr_b(rd_addr_b),
		.rd_data_b(rd_data_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
		end else if (cfg_we) begin
			width_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q <= '0;
			phase_q <= PH_FIRST;
			lsel_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && !idle_flush) begin
						state_q <= S_RD;
						if (last) begin
							col_q <= '0;
							lsel_q <= ~lsel_q;
							if (phase_q != PH_FIRST && pix.flush) begin
								phase_q <= PH_FIRST;
							end else if (phase_q != PH_LATER) begin
								phase_q <= phase_q + 2'd1;
							end
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					state_q <= has_res_q ? S_SQRT : S_IDLE;
				end
				S_SQRT: begin
					if (merge_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// capture the item, its border flags and row/frame tags on accept, the left neighbor on read
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= pix.flush ? '0 : {pix.chan2, pix.chan1, pix.chan0};
			wr_addr_q <= {~lsel_q, col_q};
			left_ok_q <= col_q != '0;
			right_ok_q <= !last;
			above_ok_q <= phase_q == PH_LATER;
			has_res_q <= phase_q != PH_FIRST;
			tag_q.row_end <= last;
			tag_q.frame_end <= last && pix.flush;
		end
		if (state_q == S_RD) begin
			left_q <= left_ok_q ? rd_data_a : '0;
		end
	end

	assign above_px = above_ok_q ? rd_data_a : '0;
	assign right_px = right_ok_q ? rd_data_b : '0;
	assign lane_start = state_q == S_WR && has_res_q;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		rgm_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.start   (lane_start),
			.cur_px  (cur_q[k*PX_W +: PX_W]),
			.above_px(above_px[k*PX_W +: PX_W]),
			.left_px (left_q[k*PX_W +: PX_W]),
			.right_px(right_px[k*PX_W +: PX_W]),
			.done    (lane_done[k]),
			.mag     (mags[k])
		);
	end

	assign merge_load = state_q == S_SQRT && (&lane_done) && merge_rdy;

	rgm_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (merge_load),
		.mags     (mags),
		.tag      (tag_q),
		.rdy      (merge_rdy),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !idle_flush |=> state_q == S_RD)
		else $error("accepted pixel did not start a line store read");

	assert property (@(posedge clk) disable iff (!arst_n)
		merge_load |-> (!res_valid || !res_stall))
		else $error("result loaded over a stalled beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res.frame_end || res.row_end))
		else $error("frame end without row end");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3 && 32'(col_q) < MAX_WIDTH)
		else $error("row phase or column out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQRT |-> has_res_q)
		else $error("square root running for a first-row pixel");

endmodule
